// ----- rtl/core/lisc_pkg.sv -----
`timescale 1ns / 1ps

package lisc_pkg;

  // Field widths of the items.
  localparam int ID_W    = 64;
  localparam int STAMP_W = 64;
  localparam int SLOT_W  = 5;

  // Default number of slots.
  localparam int DEF_SLOTS = 32;

  // Stream data widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_BITS    = 1 + SLOT_W + 1 + ID_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // One slot entry as held in memory: stamp above, id below.
  localparam int ENTRY_W = STAMP_W + ID_W;

endpackage

// ----- rtl/core/lru_id_slot_cache.sv -----
`timescale 1ns / 1ps

// Fully associative cache of 64-bit identifiers with least-recently-used
// replacement by timestamp.
// Input channel s_*: one item per identifier to look up. Output channel m_*:
// exactly one result item per input item, in order.
// Each access bumps a 64-bit use counter. A hit restamps the matching slot; a
// miss fills the first empty slot or, if all are in use, evicts the slot with
// the oldest stamp, and the new id is stored there with the new stamp.
// The slot memory is read one entry per cycle through a single compare unit,
// then the done state updates the chosen slot and loads the result.
// The result sits in an output register, so a new item is taken while it
// waits; if the receiver stalls, the next item finishes its scan and then
// holds until the output register is free.
// Reset clears the use counter and marks every slot empty at once (per-slot
// valid flags), so no clearing pass is needed.
module lru_id_slot_cache #(
  parameter int SLOTS = lisc_pkg::DEF_SLOTS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [63:0] lookup_id
  input  logic [lisc_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [0] hit, [5:1] slot, [6] evicted, [70:7] evicted_id, [71] zero
  output logic [lisc_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                     state;
  logic [lisc_pkg::ID_W-1:0]      id_q;
  logic [lisc_pkg::STAMP_W-1:0]   use_counter;
  logic [SLOTS-1:0]               valid_bits;

  logic [CNT_W-1:0]               issue_idx;
  logic                           proc_vld;
  logic [IDX_W-1:0]               proc_idx;
  logic                           proc_live;

  logic                           hit_found;
  logic [IDX_W-1:0]               hit_idx;
  logic                           empty_found;
  logic [IDX_W-1:0]               empty_idx;
  logic                           best_set;
  logic [lisc_pkg::STAMP_W-1:0]   best_stamp;
  logic [IDX_W-1:0]               best_idx;
  logic [lisc_pkg::ID_W-1:0]      best_id;

  logic                           rd_en;
  logic [lisc_pkg::ENTRY_W-1:0]   rd_data;
  logic [lisc_pkg::STAMP_W-1:0]   rd_stamp;
  logic [lisc_pkg::ID_W-1:0]      rd_id;

  logic                           wr_en;
  logic [IDX_W-1:0]               choice;
  logic [lisc_pkg::SLOT_W+IDX_W-1:0] choice_ext;
  logic                           res_evicted;
  logic [lisc_pkg::ID_W-1:0]      res_evicted_id;
  logic [lisc_pkg::OUT_TDATA_W-1:0] out_next;
  logic                           accept;
  logic                           out_free;
  logic                           scan_issue;
  logic                           scan_last;

  assign accept     = s_tvalid && s_tready;
  assign s_tready   = (state == ST_IDLE);
  assign out_free   = !m_tvalid || m_tready;
  assign scan_issue = (state == ST_SCAN) && (issue_idx < CNT_W'(SLOTS));
  assign scan_last  = proc_vld && (proc_idx == IDX_W'(SLOTS - 1));
  assign rd_en      = scan_issue;

  // An entry whose valid flag is clear reads as an empty slot.
  assign rd_stamp = proc_live ? rd_data[lisc_pkg::ENTRY_W-1:lisc_pkg::ID_W]
                              : '0;
  assign rd_id    = rd_data[lisc_pkg::ID_W-1:0];

  // Slot chosen for the update, and the result fields.
  always_comb begin
    if (hit_found) begin
      choice         = hit_idx;
      res_evicted    = 1'b0;
      res_evicted_id = '0;
    end else if (empty_found) begin
      choice         = empty_idx;
      res_evicted    = 1'b0;
      res_evicted_id = '0;
    end else begin
      choice         = best_idx;
      res_evicted    = 1'b1;
      res_evicted_id = best_id;
    end
  end

  assign choice_ext = {{lisc_pkg::SLOT_W{1'b0}}, choice};
  assign wr_en      = (state == ST_DONE) && out_free;

  assign out_next = {{(lisc_pkg::OUT_TDATA_W - lisc_pkg::OUT_BITS){1'b0}},
                     res_evicted_id, res_evicted,
                     choice_ext[lisc_pkg::SLOT_W-1:0], hit_found};

  lisc_ram #(
    .WIDTH (lisc_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (wr_en),
    .waddr (choice),
    .wdata ({use_counter, id_q}),
    .re    (rd_en),
    .raddr (issue_idx[IDX_W-1:0]),
    .rdata (rd_data)
  );

  // Sequencer: accept, scan every slot, then update and emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      use_counter <= '0;
      valid_bits  <= '0;
      issue_idx   <= '0;
      proc_vld    <= 1'b0;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
      best_set    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            use_counter <= use_counter + 1'b1;
            issue_idx   <= '0;
            proc_vld    <= 1'b0;
            hit_found   <= 1'b0;
            empty_found <= 1'b0;
            best_set    <= 1'b0;
            state       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          proc_vld <= scan_issue;
          if (scan_issue) begin
            issue_idx <= issue_idx + 1'b1;
          end
          // Shared compare unit: one slot entry per cycle.
          if (proc_vld) begin
            if (!hit_found && rd_stamp != '0 && rd_id == id_q) begin
              hit_found <= 1'b1;
            end
            if (!empty_found && rd_stamp == '0) begin
              empty_found <= 1'b1;
            end else if (rd_stamp != '0 &&
                         (!best_set || rd_stamp < best_stamp)) begin
              best_set <= 1'b1;
            end
          end
          if (scan_last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            valid_bits[choice] <= 1'b1;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers of the scan.
  always_ff @(posedge clk) begin
    if (accept) begin
      id_q <= s_tdata[lisc_pkg::ID_W-1:0];
    end
    if (scan_issue) begin
      proc_idx  <= issue_idx[IDX_W-1:0];
      proc_live <= valid_bits[issue_idx[IDX_W-1:0]];
    end
    if (state == ST_SCAN && proc_vld) begin
      if (!hit_found && rd_stamp != '0 && rd_id == id_q) begin
        hit_idx <= proc_idx;
      end
      if (!empty_found && rd_stamp == '0) begin
        empty_idx <= proc_idx;
      end else if (rd_stamp != '0 && (!best_set || rd_stamp < best_stamp)) begin
        best_stamp <= rd_stamp;
        best_idx   <= proc_idx;
        best_id    <= rd_id;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (wr_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      m_tdata <= out_next;
    end
  end

  // A result never reports both a hit and an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[6]))
    else $error("result shows hit and eviction together");

  // An eviction only happens when every slot has been filled.
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[6]) |-> (&valid_bits))
    else $error("eviction while a slot was never filled");

  // A new item starts its scan with all search flags cleared.
  a_scan_clean: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN) && !hit_found && !empty_found && !best_set)
    else $error("scan started with stale search state");

  // The update cycle never overlaps an entry still in flight from memory.
  a_done_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> !proc_vld)
    else $error("update while a read was still pending");

endmodule

// ----- rtl/core/lisc_ram.sv -----
`timescale 1ns / 1ps

module lisc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
